FILE: sv/gradient_noise_2d_core_defines.svh
// Assertion macros for the 2D gradient noise core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef GRADIENT_NOISE_2D_CORE_DEFINES_SVH
`define GRADIENT_NOISE_2D_CORE_DEFINES_SVH
`ifndef SYNTH
`define GN_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define GN_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define GN_ASSERT_IMPL(label, clk, rst, prop)
`define GN_ASSERT_NORST(label, clk, prop)
`endif
`endif

FILE: sv/gn2d_pkg.sv
// Shared constants, types and functions of the 2D gradient noise core.
// No dependencies.
package gn2d_pkg;
   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int GRAD_SLOTS_DEF      = 128;
   localparam int NUM_VERTS           = 4;
   localparam int STAGES              = 13;

   localparam logic signed [63:0] ONE_Q30    = 64'sd1073741824;
   localparam logic signed [63:0] SKEW_Q30   = 64'sd393016785;
   localparam logic signed [63:0] UNSKEW_Q30 = -64'sd226908346;
   localparam logic signed [63:0] RSQ_Q30    = 64'sd715827882;
   localparam logic signed [63:0] INVNORM_Q16 = 64'sd1195505;
   localparam logic [63:0] PRIME_X  = 64'h5205402B9270C86F;
   localparam logic [63:0] PRIME_Y  = 64'h598CD327003817B5;
   localparam logic [63:0] HASH_SCRAMBLE = 64'h53A3F72DEEC546F5;

   typedef logic signed [63:0] s64_type;
   typedef logic [63:0]        u64_type;

   typedef struct packed {
      logic signed [25:0] gx;
      logic signed [25:0] gy;
   } grad_type;

   function automatic grad_type grad_lut(input logic [4:0] idx);
      localparam logic signed [25:0] GA = 26'sd6420363;
      localparam logic signed [25:0] GB = 26'sd15500126;
      localparam logic signed [25:0] GC = 26'sd2189866;
      localparam logic signed [25:0] GD = 26'sd10213322;
      localparam logic signed [25:0] GE = 26'sd13310260;
      localparam logic signed [25:0] GF = 26'sd16633685;
      grad_type g;
      case (idx)
         5'd0:  g = '{GA, GB};   5'd1:  g = '{GB, GA};
         5'd2:  g = '{GB, -GA};  5'd3:  g = '{GA, -GB};
         5'd4:  g = '{-GA, -GB}; 5'd5:  g = '{-GB, -GA};
         5'd6:  g = '{-GB, GA};  5'd7:  g = '{-GA, GB};
         5'd8:  g = '{GC, GF};   5'd9:  g = '{GD, GE};
         5'd10: g = '{GE, GD};   5'd11: g = '{GF, GC};
         5'd12: g = '{GF, -GC};  5'd13: g = '{GE, -GD};
         5'd14: g = '{GD, -GE};  5'd15: g = '{GC, -GF};
         5'd16: g = '{-GC, -GF}; 5'd17: g = '{-GD, -GE};
         5'd18: g = '{-GE, -GD}; 5'd19: g = '{-GF, -GC};
         5'd20: g = '{-GF, GC};  5'd21: g = '{-GE, GD};
         5'd22: g = '{-GD, GE};  default: g = '{-GC, GF};
      endcase
      return g;
   endfunction

   // 7-bit slot mod 24 without a divider
   function automatic logic [4:0] slot_mod24(input logic [6:0] s);
      logic [6:0] r;
      r = s;
      if (r >= 7'd96) r = r - 7'd96;
      if (r >= 7'd48) r = r - 7'd48;
      if (r >= 7'd24) r = r - 7'd24;
      return r[4:0];
   endfunction
endpackage

FILE: sv/gn2d_if.sv
// Valid/ready channel interfaces for coordinate requests and noise results.
// No dependencies.
interface gn2d_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   modport source (output valid, coord_x, coord_y, input ready);
   modport sink   (input valid, coord_x, coord_y, output ready);
endinterface

interface gn2d_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] noise_value;
   modport source (output valid, noise_value, input ready);
   modport sink   (input valid, noise_value, output ready);
endinterface

FILE: sv/gn2d_vertex.sv
// One lattice vertex lane: offset, falloff a^4, hash, gradient and term.
// Pipelined over the shared stall enable; depends on gn2d_pkg.
module gn2d_vertex
   import gn2d_pkg::*;
(
   input  logic    clock,
   input  logic    advance,
   input  u64_type seed,
   input  s64_type dx_in,
   input  s64_type dy_in,
   input  s64_type cx_in,
   input  s64_type cy_in,
   input  logic    always_in,
   output s64_type term_out
);
   localparam logic [31:0] MIX_LO = HASH_SCRAMBLE[31:0];
   localparam logic [31:0] MIX_HI = HASH_SCRAMBLE[63:32];

   // wrapping 64-bit product of a sign-extended 32-bit cell index and a constant
   function automatic u64_type prime_mul(input logic signed [31:0] c, input u64_type k);
      logic signed [32:0] k_lo;
      s64_type            lo;
      logic [31:0]        hi;
      k_lo = {1'b0, k[31:0]};
      lo   = c * k_lo;
      hi   = c * k[63:32];
      return u64_type'(lo) + {hi, 32'd0};
   endfunction

   // stage 1: abs, hash prime products
   u64_type ux_ff, uy_ff, hx_ff, hy_ff;
   s64_type dx1_ff, dy1_ff;
   logic    al1_ff;
   always_ff @(posedge clock) if (advance) begin
      ux_ff <= dx_in[63] ? u64_type'(-dx_in) : u64_type'(dx_in);
      uy_ff <= dy_in[63] ? u64_type'(-dy_in) : u64_type'(dy_in);
      hx_ff <= prime_mul($signed(cx_in[31:0]), PRIME_X);
      hy_ff <= prime_mul($signed(cy_in[31:0]), PRIME_Y);
      dx1_ff <= dx_in; dy1_ff <= dy_in; al1_ff <= always_in;
   end
   // stage 2: squares, hash partial products
   u64_type sqx_ff, sqy_ff, pl_ff, hmix;
   logic [31:0] pa_ff, pb_ff;
   s64_type dx2_ff, dy2_ff;
   logic    al2_ff;
   always_comb hmix = seed ^ hx_ff ^ hy_ff;
   always_ff @(posedge clock) if (advance) begin
      sqx_ff <= (ux_ff[31:0] * ux_ff[31:0]) >> 30;
      sqy_ff <= (uy_ff[31:0] * uy_ff[31:0]) >> 30;
      pl_ff  <= hmix[31:0] * MIX_LO;
      pa_ff  <= hmix[31:0] * MIX_HI;
      pb_ff  <= hmix[63:32] * MIX_LO;
      dx2_ff <= dx1_ff; dy2_ff <= dy1_ff; al2_ff <= al1_ff;
   end
   // stage 3: a, hash product sum
   s64_type a_ff, dx3_ff, dy3_ff;
   u64_type h3_ff;
   logic    al3_ff;
   always_ff @(posedge clock) if (advance) begin
      a_ff  <= RSQ_Q30 - s64_type'(sqx_ff) - s64_type'(sqy_ff);
      h3_ff <= pl_ff + {pa_ff + pb_ff, 32'd0};
      dx3_ff <= dx2_ff; dy3_ff <= dy2_ff; al3_ff <= al2_ff;
   end
   // stage 4: |a|, gradient pick
   u64_type ua_ff;
   logic    live4_ff;
   grad_type g_ff;
   s64_type dx4_ff, dy4_ff;
   u64_type fold;
   always_comb fold = h3_ff ^ u64_type'($signed(h3_ff) >>> 58);
   always_ff @(posedge clock) if (advance) begin
      ua_ff    <= a_ff[63] ? u64_type'(-a_ff) : u64_type'(a_ff);
      live4_ff <= al3_ff || (a_ff > 0);
      g_ff     <= grad_lut(slot_mod24(fold[7:1]));
      dx4_ff <= dx3_ff; dy4_ff <= dy3_ff;
   end
   // stage 5: a^2, dot partials
   u64_type a2_ff;
   s64_type px_ff, py_ff;
   logic    live5_ff;
   always_ff @(posedge clock) if (advance) begin
      a2_ff <= (ua_ff[31:0] * ua_ff[31:0]) >> 30;
      px_ff <= g_ff.gx * $signed(dx4_ff[31:0]);
      py_ff <= g_ff.gy * $signed(dy4_ff[31:0]);
      live5_ff <= live4_ff;
   end
   // stage 6: a^4, dot
   u64_type a4_ff;
   s64_type dot_ff;
   logic    live6_ff;
   always_ff @(posedge clock) if (advance) begin
      a4_ff  <= (a2_ff[31:0] * a2_ff[31:0]) >> 30;
      dot_ff <= (px_ff + py_ff) >>> 24;
      live6_ff <= live5_ff;
   end
   // stage 7: term
   s64_type term_c;
   always_comb term_c = ($signed({1'b0, a4_ff[31:0]}) * $signed(dot_ff[31:0])) >>> 30;
   always_ff @(posedge clock) if (advance) begin
      term_out <= live6_ff ? term_c : '0;
   end
endmodule

FILE: sv/gn2d_front.sv
// Skew, floor, unskew and vertex selection for one coordinate pair.
// Three register stages on the shared stall enable; depends on gn2d_pkg.
module gn2d_front
   import gn2d_pkg::*;
#(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               advance,
   input  logic signed [31:0] coord_x,
   input  logic signed [31:0] coord_y,
   output s64_type            dx_out [NUM_VERTS],
   output s64_type            dy_out [NUM_VERTS],
   output s64_type            cx_out [NUM_VERTS],
   output s64_type            cy_out [NUM_VERTS],
   output logic [NUM_VERTS-1:0] always_out
);
   localparam int P = COORD_FRAC_BITS + 30;
   localparam logic signed [29:0] SKEW_K   = 30'sd393016785;
   localparam logic signed [28:0] UNSKEW_K = -29'sd226908346;
   logic signed [32:0] xy_sum;
   always_comb xy_sum = 33'(coord_x) + 33'(coord_y);
   s64_type xs_ff, ys_ff;
   always_ff @(posedge clock) if (advance) begin
      xs_ff <= (s64_type'(coord_x) <<< 30) + xy_sum * SKEW_K;
      ys_ff <= (s64_type'(coord_y) <<< 30) + xy_sum * SKEW_K;
   end
   s64_type xsb_ff, ysb_ff, xi_ff, yi_ff, t_ff;
   u64_type mask;
   s64_type xi_c, yi_c;
   logic signed [31:0] ij_sum;
   always_comb mask = (u64_type'(1) << P) - 64'd1;
   always_comb begin
      xi_c   = s64_type'((u64_type'(xs_ff) & mask) >> COORD_FRAC_BITS);
      yi_c   = s64_type'((u64_type'(ys_ff) & mask) >> COORD_FRAC_BITS);
      ij_sum = xi_c[31:0] + yi_c[31:0];
   end
   always_ff @(posedge clock) if (advance) begin
      xsb_ff <= xs_ff >>> P;
      ysb_ff <= ys_ff >>> P;
      xi_ff  <= xi_c;
      yi_ff  <= yi_c;
      t_ff   <= (ij_sum * UNSKEW_K) >>> 30;
   end
   logic signed [2:0] vi [NUM_VERTS];
   logic signed [2:0] vj [NUM_VERTS];
   always_comb begin
      vi[0] = 3'sd0; vj[0] = 3'sd0; vi[1] = 3'sd1; vj[1] = 3'sd1;
      if (t_ff < UNSKEW_Q30) begin
         if (2 * xi_ff - yi_ff > ONE_Q30) begin vi[2] = 3'sd2; vj[2] = 3'sd1; end
         else begin vi[2] = 3'sd0; vj[2] = 3'sd1; end
         if (2 * yi_ff - xi_ff > ONE_Q30) begin vi[3] = 3'sd1; vj[3] = 3'sd2; end
         else begin vi[3] = 3'sd1; vj[3] = 3'sd0; end
      end else begin
         if (2 * xi_ff - yi_ff < 0) begin vi[2] = -3'sd1; vj[2] = 3'sd0; end
         else begin vi[2] = 3'sd1; vj[2] = 3'sd0; end
         if (2 * yi_ff < xi_ff) begin vi[3] = 3'sd0; vj[3] = -3'sd1; end
         else begin vi[3] = 3'sd0; vj[3] = 3'sd1; end
      end
   end
   always_ff @(posedge clock) if (advance) begin
      for (int k = 0; k < NUM_VERTS; k++) begin
         dx_out[k] <= xi_ff + t_ff - (vi[k] * ONE_Q30
                      + (vi[k] + vj[k]) * UNSKEW_Q30);
         dy_out[k] <= yi_ff + t_ff - (vj[k] * ONE_Q30
                      + (vi[k] + vj[k]) * UNSKEW_Q30);
         cx_out[k] <= xsb_ff + s64_type'(vi[k]);
         cy_out[k] <= ysb_ff + s64_type'(vj[k]);
      end
      always_out <= 4'b0011;
   end
endmodule

FILE: sv/gradient_noise_2d_core.sv
// Top level of the 2D gradient noise core: front end, four vertex lanes, output scale.
// Depends on gn2d_pkg, gn2d_if, gn2d_front, gn2d_vertex and the defines header.
// One coordinate request per clock while the output is not stalled; the fixed pipeline has
// 3 front stages, 7 vertex-lane stages and 3 sum and scale stages. A stall at the output
// freezes the whole pipeline; the last stage keeps its result while stalled.
`include "gradient_noise_2d_core_defines.svh"
module gradient_noise_2d_core
   import gn2d_pkg::*;
#(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   gn2d_req_if.sink    req,
   gn2d_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [63:0] csr_wdata
);
   localparam logic signed [21:0] INVNORM_K = 22'sd1195505;

   u64_type seed_ff;
   always_ff @(posedge clock) begin
      if (reset) seed_ff <= '0;
      else if (csr_we) seed_ff <= csr_wdata;
   end

   logic advance;
   logic [STAGES-1:0] vld_ff;
   assign advance   = !vld_ff[STAGES-1] || rsp.ready;
   assign req.ready = advance;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[STAGES-2:0], req.valid};
   end

   s64_type dx [NUM_VERTS];
   s64_type dy [NUM_VERTS];
   s64_type cx [NUM_VERTS];
   s64_type cy [NUM_VERTS];
   s64_type term [NUM_VERTS];
   logic [NUM_VERTS-1:0] alw;

   gn2d_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
      .clock, .advance, .coord_x(req.coord_x), .coord_y(req.coord_y),
      .dx_out(dx), .dy_out(dy), .cx_out(cx), .cy_out(cy), .always_out(alw));

   for (genvar k = 0; k < NUM_VERTS; k++) begin : g_lane
      gn2d_vertex u_vtx (
         .clock, .advance, .seed(seed_ff), .dx_in(dx[k]), .dy_in(dy[k]),
         .cx_in(cx[k]), .cy_in(cy[k]), .always_in(alw[k]), .term_out(term[k]));
   end

   s64_type sum_ff, scl_ff;
   logic signed [15:0] out_ff;
   always_ff @(posedge clock) if (advance) begin
      sum_ff <= term[0] + term[1] + term[2] + term[3];
      scl_ff <= ($signed(sum_ff[31:0]) * INVNORM_K + (s64_type'(1) <<< 30)) >>> 31;
      if (scl_ff > 64'sd32767) out_ff <= 16'sd32767;
      else if (scl_ff < -64'sd32768) out_ff <= -16'sd32768;
      else out_ff <= scl_ff[15:0];
   end
   assign rsp.valid       = vld_ff[STAGES-1];
   assign rsp.noise_value = out_ff;

   `GN_ASSERT_IMPL(a_hold, clock, reset, rsp.valid && !rsp.ready |=> rsp.valid && $stable(out_ff))
   `GN_ASSERT_IMPL(a_ready, clock, reset, !rsp.valid |-> req.ready)
   `GN_ASSERT_NORST(a_rst, clock, $past(reset) |-> !rsp.valid)
endmodule
